// ----- rtl/i2cms_pkg.sv -----
package i2cms_pkg;

    localparam int DEF_BUFFER_DEPTH     = 256;
    localparam int DEF_MAX_PREFIX_BYTES = 4;

    // item kinds
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_SLAVE_ADDRESS = 3'd0;
    localparam logic [2:0] CFG_TRANSFER_MODE = 3'd1;
    localparam logic [2:0] CFG_PREFIX_BYTES  = 3'd2;
    localparam logic [2:0] CFG_PREFIX_COUNT  = 3'd3;
    localparam logic [2:0] CFG_PAYLOAD_COUNT = 3'd4;

    // bus status codes, low three bits masked off
    localparam logic [7:0] STATUS_MASK  = 8'hF8;
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RSTART    = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK = 8'h48;
    localparam logic [7:0] ST_RX_ACK    = 8'h50;
    localparam logic [7:0] ST_RX_NACK   = 8'h58;

    // transaction outcomes
    localparam logic [2:0] OUT_SENT        = 3'd0;
    localparam logic [2:0] OUT_RECEIVED    = 3'd1;
    localparam logic [2:0] OUT_NO_RESPONSE = 3'd2;
    localparam logic [2:0] OUT_ABORTED     = 3'd3;
    localparam logic [2:0] OUT_BUS_ERROR   = 3'd4;

    typedef struct packed {
        logic [6:0]  slave_address;
        logic        transfer_mode;
        logic [31:0] prefix_bytes;
        logic [2:0]  prefix_count;
        logic [7:0]  payload_count;
    } cfg_t;

    typedef struct packed {
        logic       cmd_start;
        logic       cmd_stop;
        logic       cmd_ack;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_from_store;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       done_res;
        logic [2:0] outcome;
        logic       busy_res;
    } res_t;

endpackage

// ----- rtl/i2c_master_transaction_sequencer_top.sv -----
// Channel  | Handshake          | Words carried
// ---------+--------------------+-------------------------------------------------------
// s_       | s_valid / s_ready  | op, status_code, bus_rx_byte, load_index, load_byte
// m_       | m_valid / m_ready  | commands, tx byte, rx byte and index, outcome, busy
// cfg_     | cfg_valid/cfg_ready| cfg_index (register number), cfg_data
//
// One word per cycle sustained while m_ is not stalled; a result passes through the stage one
// register and then the output register before it is presented on m_.
// Stage one decides and reads the send store (one read port, registered data); stage
// two picks the store byte and fills the output register.
// Reset is synchronous and clears the sequencer state and the configuration registers;
// the send store is not cleared and must be loaded before it is sent.
// A stalled m_ channel holds stage two, then stage one, then drops s_ready.
module i2c_master_transaction_sequencer_top
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH     = DEF_BUFFER_DEPTH,
    parameter int MAX_PREFIX_BYTES = DEF_MAX_PREFIX_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_status_code,
    input  logic [7:0]  s_bus_rx_byte,
    input  logic [7:0]  s_load_index,
    input  logic [7:0]  s_load_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_cmd_start,
    output logic        m_cmd_stop,
    output logic        m_cmd_ack,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_rx_valid,
    output logic [7:0]  m_rx_byte,
    output logic [7:0]  m_rx_index,
    output logic        m_done_res,
    output logic [2:0]  m_outcome,
    output logic        m_busy_res
);

    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    cfg_t              cfg_reg;
    logic              s_accept;
    res_t              step_res;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              load_en;

    logic [7:0]        store_mem [BUFFER_DEPTH];
    logic [7:0]        store_q_reg;

    res_t              p1_reg;
    logic              p1_valid_reg;
    logic              p1_adv;
    res_t              out_reg, out_next;
    logic              out_valid_reg;

    // configuration: always ready, write on handshake
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SLAVE_ADDRESS: cfg_reg.slave_address <= cfg_data[6:0];
                CFG_TRANSFER_MODE: cfg_reg.transfer_mode <= cfg_data[0];
                CFG_PREFIX_BYTES:  cfg_reg.prefix_bytes  <= cfg_data;
                CFG_PREFIX_COUNT:  cfg_reg.prefix_count  <= cfg_data[2:0];
                CFG_PAYLOAD_COUNT: cfg_reg.payload_count <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // stage two advances when the output register is empty or being taken
    assign p1_adv   = !out_valid_reg || m_ready;
    assign s_ready  = !p1_valid_reg || p1_adv;
    assign s_accept = s_valid && s_ready;

    i2cms_seq #(
        .BUFFER_DEPTH     (BUFFER_DEPTH),
        .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .step_en     (s_accept),
        .op          (s_op),
        .status_code (s_status_code),
        .bus_rx_byte (s_bus_rx_byte),
        .res         (step_res),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr)
    );

    // Send store: one write port for loads, one read port for sends. A load and a
    // later send are never taken on the same edge, so the read always sees the write.
    assign load_en = s_accept && (s_op == OP_LOAD) && ({1'b0, s_load_index} < 9'(BUFFER_DEPTH));

    always_ff @(posedge aclk) begin
        if (load_en) begin
            store_mem[s_load_index[ADDR_W-1:0]] <= s_load_byte;
        end
    end

    // read data only changes with a new word, so it holds while stage one is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            store_q_reg <= store_mem[rd_addr];
        end
    end

    // stage one: decision result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_reg <= step_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    // stage two: merge the store byte into the result word
    always_comb begin
        out_next               = p1_reg;
        out_next.tx_byte       = p1_reg.tx_from_store ? store_q_reg : p1_reg.tx_byte;
        out_next.tx_from_store = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_cmd_start = out_reg.cmd_start;
    assign m_cmd_stop  = out_reg.cmd_stop;
    assign m_cmd_ack   = out_reg.cmd_ack;
    assign m_tx_valid  = out_reg.tx_valid;
    assign m_tx_byte   = out_reg.tx_byte;
    assign m_rx_valid  = out_reg.rx_valid;
    assign m_rx_byte   = out_reg.rx_byte;
    assign m_rx_index  = out_reg.rx_index;
    assign m_done_res  = out_reg.done_res;
    assign m_outcome   = out_reg.outcome;
    assign m_busy_res  = out_reg.busy_res;

    // a finished transaction never reports itself as still busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done result reports busy");

    // a result never both sends and receives a byte
    a_tx_rx_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_tx_valid && m_rx_valid))
        else $error("tx and rx in one result");

    // a start word lands in stage one requesting start and busy
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_op == OP_START) |=> p1_valid_reg && p1_reg.cmd_start && p1_reg.busy_res)
        else $error("start word lost its start or busy flag");

    // a stalled output keeps stage one from being overwritten
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && out_valid_reg && !m_ready |-> !s_ready)
        else $error("stage one overwritten under stall");

endmodule

// ----- rtl/i2cms_seq.sv -----
module i2cms_seq
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH     = DEF_BUFFER_DEPTH,
    parameter int MAX_PREFIX_BYTES = DEF_MAX_PREFIX_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              step_en,
    input  logic [1:0]        op,
    input  logic [7:0]        status_code,
    input  logic [7:0]        bus_rx_byte,
    output res_t              res,
    output logic              rd_en,
    output logic [((BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1)-1:0] rd_addr
);

    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [8:0] send_pos_reg, send_pos_next;
    logic [7:0] recv_pos_reg, recv_pos_next;
    logic       busy_reg, busy_next;

    logic [7:0] st;
    logic [3:0] pfx_cnt;
    logic [8:0] send_len;
    logic [7:0] recv_last;
    logic [8:0] pos_eff;
    logic [8:0] store_off;
    logic       in_store;
    logic [7:0] pfx_byte;
    logic       send_step;
    logic       nacked;

    assign st        = status_code & STATUS_MASK;
    assign pfx_cnt   = ({1'b0, cfg.prefix_count} > 4'(MAX_PREFIX_BYTES))
                       ? 4'(MAX_PREFIX_BYTES) : {1'b0, cfg.prefix_count};
    assign send_len  = 9'(pfx_cnt) + (cfg.transfer_mode ? 9'd0 : {1'b0, cfg.payload_count});
    assign recv_last = (cfg.payload_count == 8'd0) ? 8'd0 : cfg.payload_count - 8'd1;
    // the first data byte after SLA+W restarts the send phase
    assign pos_eff   = (st == ST_SLAW_ACK) ? 9'd0 : send_pos_reg;
    assign store_off = pos_eff - 9'(pfx_cnt);
    assign in_store  = (pos_eff >= 9'(pfx_cnt)) && (store_off < 9'(BUFFER_DEPTH));
    assign pfx_byte  = ((pos_eff < 9'(pfx_cnt)) && (pos_eff < 9'd4))
                       ? cfg.prefix_bytes[{pos_eff[1:0], 3'b000} +: 8] : 8'd0;
    assign rd_addr   = store_off[ADDR_W-1:0];

    always_comb begin
        res           = '0;
        send_pos_next = send_pos_reg;
        recv_pos_next = recv_pos_reg;
        busy_next     = busy_reg;
        rd_en         = 1'b0;
        send_step     = 1'b0;
        nacked        = 1'b0;
        if (step_en) begin
            priority if (op == OP_START) begin
                send_pos_next = 9'd0;
                recv_pos_next = 8'd0;
                busy_next     = 1'b1;
                res.cmd_start = 1'b1;
            end else if (op == OP_EVENT && busy_reg) begin
                unique case (st)
                    ST_START: begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = {cfg.slave_address, 1'b0};
                    end
                    ST_RSTART: begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = {cfg.slave_address, 1'b1};
                    end
                    ST_SLAW_ACK: begin
                        send_pos_next = 9'd0;
                        send_step     = 1'b1;
                    end
                    ST_DATA_ACK: begin
                        send_step = 1'b1;
                    end
                    ST_DATA_NACK: begin
                        send_step = 1'b1;
                        nacked    = 1'b1;
                    end
                    ST_SLAR_ACK: begin
                        recv_pos_next = 8'd0;
                        res.cmd_ack   = (recv_last != 8'd0);
                    end
                    ST_SLAW_NACK, ST_SLAR_NACK: begin
                        res.cmd_stop = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OUT_NO_RESPONSE;
                        busy_next    = 1'b0;
                    end
                    ST_RX_ACK: begin
                        res.rx_valid  = 1'b1;
                        res.rx_byte   = bus_rx_byte;
                        res.rx_index  = recv_pos_reg;
                        recv_pos_next = recv_pos_reg + 8'd1;
                        res.cmd_ack   = (recv_pos_next != recv_last);
                    end
                    ST_RX_NACK: begin
                        res.rx_valid  = 1'b1;
                        res.rx_byte   = bus_rx_byte;
                        res.rx_index  = recv_pos_reg;
                        recv_pos_next = recv_pos_reg + 8'd1;
                        res.cmd_stop  = 1'b1;
                        res.done_res  = 1'b1;
                        res.outcome   = OUT_RECEIVED;
                        busy_next     = 1'b0;
                    end
                    default: begin
                        res.cmd_stop = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OUT_BUS_ERROR;
                        busy_next    = 1'b0;
                    end
                endcase

                if (send_step) begin
                    priority if (pos_eff >= send_len) begin
                        // nothing left to send: repeated start or stop
                        if (cfg.transfer_mode) begin
                            res.cmd_start = 1'b1;
                        end else begin
                            res.cmd_stop = 1'b1;
                            res.done_res = 1'b1;
                            res.outcome  = OUT_SENT;
                            busy_next    = 1'b0;
                        end
                    end else if (nacked) begin
                        res.cmd_stop = 1'b1;
                        res.done_res = 1'b1;
                        res.outcome  = OUT_ABORTED;
                        busy_next    = 1'b0;
                    end else begin
                        res.tx_valid      = 1'b1;
                        res.tx_byte       = pfx_byte;
                        res.tx_from_store = in_store;
                        rd_en             = in_store;
                        send_pos_next     = pos_eff + 9'd1;
                    end
                end
            end else begin
                busy_next = busy_reg;
            end
        end
        res.busy_res = busy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_pos_reg <= 9'd0;
            recv_pos_reg <= 8'd0;
            busy_reg     <= 1'b0;
        end else begin
            send_pos_reg <= send_pos_next;
            recv_pos_reg <= recv_pos_next;
            busy_reg     <= busy_next;
        end
    end

endmodule
